// ===== sv/svdcd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svdcd_pkg
// shared constants, types and character helpers for the valve / dac decoder
// ----------------------------------------------------------------------------
package svdcd_pkg;

    localparam int LINE_BYTES = 11;
    localparam int CNT_W      = $clog2(LINE_BYTES);

    typedef logic [7:0] t_byte;

    // characters
    localparam t_byte CHAR_CR   = 8'h0D;
    localparam t_byte CHAR_0    = 8'h30;
    localparam t_byte CHAR_1    = 8'h31;
    localparam t_byte CHAR_9    = 8'h39;
    localparam t_byte CHAR_UA   = 8'h41;
    localparam t_byte CHAR_UB   = 8'h42;
    localparam t_byte CHAR_UD   = 8'h44;
    localparam t_byte CHAR_UF   = 8'h46;
    localparam t_byte CHAR_UG   = 8'h47;
    localparam t_byte CHAR_UR   = 8'h52;
    localparam t_byte CHAR_UV   = 8'h56;
    localparam t_byte CHAR_LA   = 8'h61;
    localparam t_byte CHAR_LF   = 8'h66;

    // dac command bytes
    localparam t_byte CMD_DAC_A = 8'h18;
    localparam t_byte CMD_DAC_B = 8'h19;

    // action codes
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_VALVE = 2'd1;
    localparam logic [1:0] ACT_DAC   = 2'd2;

    // status codes
    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_A_OFF = 3'd1;
    localparam logic [2:0] ST_A_ON  = 3'd2;
    localparam logic [2:0] ST_B_OFF = 3'd3;
    localparam logic [2:0] ST_B_ON  = 3'd4;
    localparam logic [2:0] ST_DAC_A = 3'd5;
    localparam logic [2:0] ST_DAC_B = 3'd6;

    // one completed line, bytes past the last received one read as zero
    typedef struct packed {
        logic                       valid;
        logic [LINE_BYTES-1:0][7:0] bytes;
    } t_line;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input t_byte c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            r = {1'b1, 4'(c - CHAR_0)};
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            r = {1'b1, 4'(c - CHAR_UA + 8'd10)};
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            r = {1'b1, 4'(c - CHAR_LA + 8'd10)};
        end
        return r;
    endfunction

    // up to two hex digits, stops at the first non-hex character
    function automatic t_byte parse_pair(input t_byte c0, input t_byte c1);
        logic [4:0] d0;
        logic [4:0] d1;
        t_byte      r;
        d0 = hex_digit(c0);
        d1 = hex_digit(c1);
        if (!d0[4]) begin
            r = 8'd0;
        end else if (!d1[4]) begin
            r = {4'd0, d0[3:0]};
        end else begin
            r = {d0[3:0], d1[3:0]};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/svdcd_line.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svdcd_line
// line buffer: collects bytes and hands a finished line to the decoder
// ----------------------------------------------------------------------------
module svdcd_line import svdcd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_rx_valid,
    output logic       o_rx_stall,
    input  wire t_byte i_rx_byte,
    input  wire logic  i_line_take,
    output t_line      o_line
);

    localparam logic [CNT_W-1:0] LINE_LAST = CNT_W'(LINE_BYTES - 1);

    t_byte                      r_buf [LINE_BYTES];
    logic [CNT_W-1:0]           r_count;
    logic                       r_line_valid;
    logic [LINE_BYTES-1:0][7:0] r_line_bytes;
    logic [LINE_BYTES-1:0][7:0] n_line_bytes;
    logic                       accept;
    logic                       line_end;

    assign o_rx_stall = r_line_valid && !i_line_take;
    assign accept     = i_rx_valid && !o_rx_stall;
    assign line_end   = (i_rx_byte == CHAR_CR) || (r_count == LINE_LAST);

    // snapshot of the line including the byte now arriving
    always_comb begin
        for (int k = 0; k < LINE_BYTES; k++) begin
            if (CNT_W'(k) < r_count) begin
                n_line_bytes[k] = r_buf[k];
            end else if (CNT_W'(k) == r_count) begin
                n_line_bytes[k] = i_rx_byte;
            end else begin
                n_line_bytes[k] = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !line_end) begin
            r_buf[r_count] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept) begin
            r_count <= line_end ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_valid <= 1'b0;
        end else if (accept && line_end) begin
            r_line_valid <= 1'b1;
        end else if (i_line_take) begin
            r_line_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && line_end) begin
            r_line_bytes <= n_line_bytes;
        end
    end

    assign o_line = {r_line_valid, r_line_bytes};

`ifndef SYNTH
    a_count_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LINE_LAST)
        else $error("byte count past line end");

    a_end_hands_off : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && line_end |=> r_count == '0 && r_line_valid)
        else $error("line end did not restart buffer");

    a_take_needs_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_line_valid |-> !o_rx_stall)
        else $error("stall without pending line");
`endif

endmodule
`default_nettype wire

// ===== sv/svdcd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// svdcd_decode
// command decode, valve levels and the result register
// ----------------------------------------------------------------------------
module svdcd_decode import svdcd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_dev_addr,
    input  wire t_line      i_line,
    output logic            o_line_take,
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [1:0]      o_action,
    output logic [2:0]      o_status_code,
    output logic            o_valve_a_on,
    output logic            o_valve_b_on,
    output t_byte           o_dac_command,
    output t_byte           o_dac_high,
    output t_byte           o_dac_low
);

    logic                  r_valve_a;
    logic                  r_valve_b;
    logic                  r_res_valid;
    logic [1:0]            r_action;
    logic [2:0]            r_status;
    logic                  r_out_a;
    logic                  r_out_b;
    t_byte                 r_cmd;
    t_byte                 r_hi;
    t_byte                 r_lo;

    logic [1:0]            n_action;
    logic [2:0]            n_status;
    logic                  n_valve_a;
    logic                  n_valve_b;
    t_byte                 n_cmd;
    t_byte                 n_hi;
    t_byte                 n_lo;

    logic [LINE_BYTES-1:0] nz;
    logic                  len7;
    logic                  len10;
    logic                  head;
    t_byte                 addr_char;
    t_byte                 v;
    t_byte                 s;
    logic                  lvl;

    assign o_line_take = i_line.valid && (!r_res_valid || !i_res_stall);

    always_comb begin
        for (int k = 0; k < LINE_BYTES; k++) begin
            nz[k] = i_line.bytes[k] != 8'd0;
        end
    end

    // length is the count of bytes before the first zero
    assign len7      = (&nz[6:0]) && !nz[7];
    assign len10     = (&nz[9:0]) && !nz[10];
    assign addr_char = CHAR_0 + {6'd0, i_dev_addr};
    assign head      = i_line.bytes[0] == CHAR_UG && i_line.bytes[1] == CHAR_UR &&
                       i_line.bytes[2] == addr_char;
    assign v         = i_line.bytes[4];
    assign s         = i_line.bytes[5];
    assign lvl       = s == CHAR_1;

    always_comb begin
        n_action  = ACT_NONE;
        n_status  = ST_NONE;
        n_valve_a = r_valve_a;
        n_valve_b = r_valve_b;
        n_cmd     = 8'd0;
        n_hi      = 8'd0;
        n_lo      = 8'd0;
        if (head && i_line.bytes[3] == CHAR_UV && len7) begin
            if ((v == CHAR_0 || v == CHAR_1) && (s == CHAR_0 || s == CHAR_1)) begin
                n_action = ACT_VALVE;
                if (v == CHAR_0) begin
                    n_valve_a = lvl;
                    n_status  = lvl ? ST_A_ON : ST_A_OFF;
                end else begin
                    n_valve_b = lvl;
                    n_status  = lvl ? ST_B_ON : ST_B_OFF;
                end
            end
        end else if (head && i_line.bytes[3] == CHAR_UD &&
                     (v == CHAR_UA || v == CHAR_UB) && len10) begin
            n_action = ACT_DAC;
            n_hi     = parse_pair(i_line.bytes[5], i_line.bytes[6]);
            n_lo     = parse_pair(i_line.bytes[7], i_line.bytes[8]);
            n_cmd    = (v == CHAR_UA) ? CMD_DAC_A : CMD_DAC_B;
            n_status = (v == CHAR_UA) ? ST_DAC_A : ST_DAC_B;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_a   <= 1'b0;
            r_valve_b   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_line_take) begin
                r_valve_a   <= n_valve_a;
                r_valve_b   <= n_valve_b;
                r_res_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_line_take) begin
            r_action <= n_action;
            r_status <= n_status;
            r_out_a  <= n_valve_a;
            r_out_b  <= n_valve_b;
            r_cmd    <= n_cmd;
            r_hi     <= n_hi;
            r_lo     <= n_lo;
        end
    end

    assign o_res_valid   = r_res_valid;
    assign o_action      = r_action;
    assign o_status_code = r_status;
    assign o_valve_a_on  = r_out_a;
    assign o_valve_b_on  = r_out_b;
    assign o_dac_command = r_cmd;
    assign o_dac_high    = r_hi;
    assign o_dac_low     = r_lo;

`ifndef SYNTH
    a_none_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_action == ACT_NONE |->
            r_status == ST_NONE && r_cmd == 8'd0 && r_hi == 8'd0 && r_lo == 8'd0)
        else $error("no-command result carries data");

    a_valve_a_on : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_status == ST_A_ON |-> r_out_a && r_action == ACT_VALVE)
        else $error("valve a status and level disagree");

    a_dac_cmd : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_action == ACT_DAC |->
            (r_cmd == CMD_DAC_A && r_status == ST_DAC_A) ||
            (r_cmd == CMD_DAC_B && r_status == ST_DAC_B))
        else $error("dac command and status disagree");

    a_level_follows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_line_take |=> r_out_a == r_valve_a && r_out_b == r_valve_b)
        else $error("reported valve level differs from held level");
`endif

endmodule
`default_nettype wire

// ===== sv/serial_valve_dac_command_decoder.sv =====
// throughput: one received byte per cycle, every cycle, with a free result slot
// a line's last byte transfer loads the line snapshot, and the result register is
//   loaded from the snapshot when the decoder takes the line
// a stalled result holds one more finished line in the snapshot before input stalls
// reset (synchronous, active low) empties the line, clears both valve levels,
//   the device address and both valid flags; the line buffer itself is not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// serial_valve_dac_command_decoder
// collects serial bytes into lines and decodes valve and dac commands
// ----------------------------------------------------------------------------
module serial_valve_dac_command_decoder import svdcd_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_wdata,
    // received byte channel
    input  wire logic       i_rx_valid,
    output logic            o_rx_stall,
    input  wire logic [7:0] i_rx_byte,
    // result channel
    output logic            o_res_valid,
    input  wire logic       i_res_stall,
    output logic [1:0]      o_action,
    output logic [2:0]      o_status_code,
    output logic            o_valve_a_on,
    output logic            o_valve_b_on,
    output logic [7:0]      o_dac_command,
    output logic [7:0]      o_dac_high,
    output logic [7:0]      o_dac_low
);

    // jumper address; write only while no line is in flight, the block does not enforce this
    logic [1:0] r_dev_addr;
    // finished line between buffer and decoder
    t_line      line;
    // decoder pulls the snapshot when its result slot is free
    logic       line_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= 2'd0;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // byte collection, line end on carriage return or full buffer
    svdcd_line u_line (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_stall  (o_rx_stall),
        .i_rx_byte   (i_rx_byte),
        .i_line_take (line_take),
        .o_line      (line)
    );

    // one result per finished line, valve state lives here
    svdcd_decode u_decode (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_dev_addr    (r_dev_addr),
        .i_line        (line),
        .o_line_take   (line_take),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_action      (o_action),
        .o_status_code (o_status_code),
        .o_valve_a_on  (o_valve_a_on),
        .o_valve_b_on  (o_valve_b_on),
        .o_dac_command (o_dac_command),
        .o_dac_high    (o_dac_high),
        .o_dac_low     (o_dac_low)
    );

`ifndef SYNTH
    a_take_only_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_take |-> line.valid)
        else $error("decoder took an empty snapshot");

    a_res_after_take : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        line_take |=> o_res_valid)
        else $error("taken line gave no result");

    a_stall_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> o_res_valid && i_res_stall)
        else $error("input stalled with result path free");
`endif

endmodule
`default_nettype wire
